FILE: hw/rtl/lz_flag_group_compressor_core_defines.svh
// Assertion macros shared by the compressor RTL.
`ifndef LZ_FLAG_GROUP_COMPRESSOR_CORE_DEFINES_SVH
`define LZ_FLAG_GROUP_COMPRESSOR_CORE_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define LZFGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define LZFGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lzfgc_pkg.sv
// ----------------------------------------------------------------------------
// lzfgc_pkg
// Shared constants and types of the flag-group LZ compressor.
// ----------------------------------------------------------------------------
package lzfgc_pkg;

  localparam int BUFFER_DEPTH_DEF = 4096;
  localparam int IN_FIFO_DEPTH    = 2;
  localparam int OUT_FIFO_DEPTH   = 4;
  localparam int BW_WIDTH         = 13;

  localparam logic [7:0] MAX_LEN    = 8'd255;
  localparam logic [7:0] MAX_DIST   = 8'd255;
  localparam logic [7:0] MIN_LEN    = 8'd2;
  localparam logic [3:0] GROUP_SIZE = 4'd8;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_COMPRESS = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] source_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                group_last;
    logic                stream_end;
    logic [BW_WIDTH-1:0] byte_count;
    logic                overflowed;
  } result_t;

endpackage

FILE: hw/rtl/lzfgc_ram.sv
// ----------------------------------------------------------------------------
// lzfgc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module lzfgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: hw/rtl/lzfgc_fifo.sv
// ----------------------------------------------------------------------------
// lzfgc_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module lzfgc_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/lzfgc_engine.sv
// ----------------------------------------------------------------------------
// lzfgc_engine
// Back end: stores loads, runs the match search and emits each group.
// ----------------------------------------------------------------------------
`include "lz_flag_group_compressor_core_defines.svh"

module lzfgc_engine
  import lzfgc_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   in_item_i,
  input  logic    in_empty_i,
  output logic    in_pop_o,
  output result_t out_res_o,
  input  logic    out_full_i,
  output logic    out_push_o
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int SW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_ISSUE, S_CMP, S_DEND, S_LIT_RD, S_LIT, S_CMD_DONE,
    S_EMIT, S_PAD, S_END
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       loaded_q, loaded_d, pos_q, pos_d;
  logic [BW_WIDTH-1:0] wc_q, wc_d;
  logic                ovf_q, ovf_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [4:0]          n_q, n_d, e_q, e_d;
  logic [7:0]          flag_q, flag_d;
  logic [7:0]          len_q, len_d, dist_q, dist_d;
  logic [7:0]          best_len_q, best_len_d, best_dist_q, best_dist_d;
  logic [7:0]          cmd_q [16];

  logic          cmd_we0, cmd_we1;
  logic [3:0]    cmd_wa;
  logic [7:0]    cmd_wd0, cmd_wd1;
  logic          ram_we;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [7:0]    rdata_a, rdata_b;
  logic [SW-1:0] cur_sum, ref_sum;
  logic          in_range, store_full, ending, upd;
  logic [7:0]    nb_len, nb_dist;
  logic [7:0]    emit_byte;
  logic [3:0]    e_idx;

  assign cur_sum    = SW'(pos_q) + SW'(len_q);
  assign ref_sum    = cur_sum - SW'(dist_q);
  assign in_range   = (len_q != MAX_LEN) && (cur_sum < SW'(loaded_q));
  assign store_full = (SW'(loaded_q) >= SW'(BUFFER_DEPTH));
  assign ending     = (pos_q >= loaded_q);
  assign upd        = (len_q > MIN_LEN) && (len_q > best_len_q);
  assign nb_len     = upd ? len_q  : best_len_q;
  assign nb_dist    = upd ? dist_q : best_dist_q;
  assign e_idx      = 4'(e_q - 5'd1);
  assign emit_byte  = (e_q == '0) ? flag_q : cmd_q[e_idx];

  assign raddr_a = (state_q == S_LIT_RD) ? AW'(pos_q) : AW'(cur_sum);
  assign raddr_b = AW'(ref_sum);
  assign ram_we  = (state_q == S_IDLE) && !in_empty_i && (in_item_i.op == OP_LOAD) &&
                   !store_full;

  lzfgc_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (AW'(loaded_q)),
    .wdata_i   (in_item_i.source_byte),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    pos_d       = pos_q;
    wc_d        = wc_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    e_d         = e_q;
    flag_d      = flag_q;
    len_d       = len_q;
    dist_d      = dist_q;
    best_len_d  = best_len_q;
    best_dist_d = best_dist_q;
    in_pop_o    = 1'b0;
    out_push_o  = 1'b0;
    out_res_o   = '0;
    cmd_we0     = 1'b0;
    cmd_we1     = 1'b0;
    cmd_wa      = n_q[3:0];
    cmd_wd0     = rdata_a;
    cmd_wd1     = 8'h00;

    case (state_q)
      S_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          if (in_item_i.op == OP_LOAD) begin
            if (store_full) begin
              ovf_d = 1'b1;
            end else begin
              loaded_d = loaded_q + 1'b1;
            end
          end else begin
            cnt_d   = '0;
            n_d     = '0;
            flag_d  = '0;
            state_d = ending ? S_PAD : S_CMD;
          end
        end
      end
      S_CMD: begin
        best_len_d  = '0;
        best_dist_d = '0;
        len_d       = '0;
        dist_d      = 8'd1;
        state_d     = (pos_q != '0) ? S_ISSUE : S_LIT_RD;
      end
      S_ISSUE: begin
        state_d = in_range ? S_CMP : S_DEND;
      end
      S_CMP: begin
        if (rdata_a == rdata_b) begin
          len_d   = len_q + 1'b1;
          state_d = S_ISSUE;
        end else begin
          state_d = S_DEND;
        end
      end
      S_DEND: begin
        best_len_d  = nb_len;
        best_dist_d = nb_dist;
        if ((dist_q != MAX_DIST) && (SW'(dist_q) + SW'(1) <= SW'(pos_q))) begin
          dist_d  = dist_q + 1'b1;
          len_d   = '0;
          state_d = S_ISSUE;
        end else if (nb_len != '0) begin
          // match: length, then negated distance
          cmd_we0 = 1'b1;
          cmd_we1 = 1'b1;
          cmd_wd0 = nb_len;
          cmd_wd1 = 8'h00 - nb_dist;
          n_d     = n_q + 5'd2;
          pos_d   = pos_q + CW'(nb_len);
          state_d = S_CMD_DONE;
        end else begin
          state_d = S_LIT_RD;
        end
      end
      S_LIT_RD: begin
        state_d = S_LIT;
      end
      S_LIT: begin
        cmd_we0             = 1'b1;
        cmd_wd0             = rdata_a;
        flag_d[cnt_q[2:0]]  = 1'b1;
        n_d                 = n_q + 5'd1;
        pos_d               = pos_q + 1'b1;
        state_d             = S_CMD_DONE;
      end
      S_CMD_DONE: begin
        cnt_d = cnt_q + 1'b1;
        if ((cnt_q + 1'b1 < GROUP_SIZE) && !ending) begin
          state_d = S_CMD;
        end else begin
          e_d     = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        out_res_o.out_byte   = emit_byte;
        out_res_o.group_last = !ending && (e_q == n_q);
        out_res_o.stream_end = 1'b0;
        out_res_o.byte_count = wc_q + 1'b1;
        out_res_o.overflowed = ovf_q;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          wc_d       = wc_q + 1'b1;
          e_d        = e_q + 1'b1;
          if (e_q == n_q) begin
            if (!ending) begin
              state_d = S_IDLE;
            end else begin
              state_d = (cnt_q == GROUP_SIZE) ? S_PAD : S_END;
            end
          end
        end
      end
      S_PAD: begin
        out_res_o.byte_count = wc_q + 1'b1;
        out_res_o.overflowed = ovf_q;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          wc_d       = wc_q + 1'b1;
          state_d    = S_END;
        end
      end
      S_END: begin
        out_res_o.group_last = 1'b1;
        out_res_o.stream_end = 1'b1;
        out_res_o.byte_count = wc_q + 1'b1;
        out_res_o.overflowed = ovf_q;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          // clear the stream
          loaded_d   = '0;
          pos_d      = '0;
          wc_d       = '0;
          ovf_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loaded_q    <= '0;
      pos_q       <= '0;
      wc_q        <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      n_q         <= '0;
      e_q         <= '0;
      flag_q      <= '0;
      len_q       <= '0;
      dist_q      <= '0;
      best_len_q  <= '0;
      best_dist_q <= '0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      pos_q       <= pos_d;
      wc_q        <= wc_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      e_q         <= e_d;
      flag_q      <= flag_d;
      len_q       <= len_d;
      dist_q      <= dist_d;
      best_len_q  <= best_len_d;
      best_dist_q <= best_dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_we0) begin
      cmd_q[cmd_wa] <= cmd_wd0;
    end
    if (cmd_we1) begin
      cmd_q[4'(cmd_wa + 4'd1)] <= cmd_wd1;
    end
  end

  `LZFGC_ASSERT(a_pos_le_loaded, pos_q <= loaded_q, "read position passed loaded count")
  `LZFGC_ASSERT_IMP(a_push_room, out_push_o, !out_full_i, "push into full result queue")
  `LZFGC_ASSERT_IMP(a_grp, state_q == S_EMIT, cnt_q <= GROUP_SIZE && n_q <= 5'd16, "overrun")
  `LZFGC_ASSERT_IMP(a_cmp_in_range, state_q == S_CMP, $past(in_range), "compare issued out of range")

endmodule

FILE: hw/rtl/lz_flag_group_compressor_core.sv
// Sequencing: a load is taken by the engine in S_IDLE. A compress request runs, per command,
//   a search over distances d <= min(255, pos), then writes a match or a literal; then the
//   group's bytes are emitted (up to 19), stalling while the result queue is full.
// Throughput: one item at a time in the engine, set by the single match-search loop
//   over the two-read-port source store; the two-entry input queue accepts meanwhile.
// Reset: asynchronous active-low; clears counters, queues and state, not the store.
// ----------------------------------------------------------------------------
// lz_flag_group_compressor_core
// LZSS compressor with flag-byte groups: input queue, engine, result queue.
// ----------------------------------------------------------------------------
module lz_flag_group_compressor_core
  import lzfgc_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                op_i,
  input  logic [7:0]          source_byte_i,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_byte_o,
  output logic                group_last_o,
  output logic                stream_end_o,
  output logic [BW_WIDTH-1:0] byte_count_o,
  output logic                overflowed_o
);

  item_t   in_item, eng_item;
  result_t eng_res, out_res;
  logic    in_empty, in_pop, out_full, out_push;

  // Pack the request fields for the front queue.
  assign in_item.op          = op_i;
  assign in_item.source_byte = source_byte_i;

  // Front: hold requests while the engine is busy.
  lzfgc_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (IN_FIFO_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_item),
    .full_o  (full),
    .pop_i   (in_pop),
    .rdata_o (eng_item),
    .empty_o (in_empty)
  );

  // Back: store loads, search matches, build and emit groups.
  lzfgc_engine #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (eng_item),
    .in_empty_i (in_empty),
    .in_pop_o   (in_pop),
    .out_res_o  (eng_res),
    .out_full_i (out_full),
    .out_push_o (out_push)
  );

  // Result queue: decouple the engine from the consumer.
  lzfgc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (eng_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign out_byte_o   = out_res.out_byte;
  assign group_last_o = out_res.group_last;
  assign stream_end_o = out_res.stream_end;
  assign byte_count_o = out_res.byte_count;
  assign overflowed_o = out_res.overflowed;

endmodule
